>>> rtl/debounced_lap_timer_macros.svh
// Assertion macros for the debounced lap timer.
// Users must have clk and rst in scope; no other dependencies.
`ifndef DEBOUNCED_LAP_TIMER_MACROS_SVH
`define DEBOUNCED_LAP_TIMER_MACROS_SVH

// Condition that must hold in the same cycle as the trigger.
`define DLT_ASSERT_HOLDS(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define DLT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/dlt_pkg.sv
// Shared constants for the debounced lap timer.
// Field widths, item kinds, register indexes and divider constants; no dependencies.
package dlt_pkg;

  localparam int DEF_TIME_BITS = 48;

  localparam int FUNC_W     = 2;
  localparam int LAP_W      = 16;
  localparam int MIN_W      = 16;
  localparam int SEC_W      = 6;
  localparam int MICRO_W    = 20;
  localparam int MIN_LAP_W  = 32;
  localparam int QUIET_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET   = 2'd1;

  localparam logic [MIN_LAP_W-1:0] MIN_LAP_RESET = 32'd2000000;
  localparam logic [QUIET_W-1:0]   QUIET_RESET   = 24'd15000;

  localparam int US_PER_MIN = 60000000;
  localparam int US_PER_SEC = 1000000;

  // Both divisors carry a power of two that is split off as plain low bits.
  localparam int MIN_SHIFT   = 8;
  localparam int SEC_SHIFT   = 6;
  localparam int MIN_DIVISOR = US_PER_MIN / (1 << MIN_SHIFT);
  localparam int SEC_DIVISOR = US_PER_SEC / (1 << SEC_SHIFT);
  localparam int MIN_REM_W   = $clog2(MIN_DIVISOR);
  localparam int SEC_REM_W   = $clog2(SEC_DIVISOR);

  localparam int DIV_STEPS = 4;

endpackage

>>> rtl/dlt_item_if.sv
// Input item channel of the debounced lap timer.
// Depends on dlt_pkg for the field widths.
interface dlt_item_if import dlt_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [TIME_BITS-1:0] now_us;

  modport source (output valid, output func, output now_us, input ready);
  modport sink (input valid, input func, input now_us, output ready);
endinterface

>>> rtl/dlt_lap_if.sv
// Lap result channel of the debounced lap timer.
// Depends on dlt_pkg for the field widths.
interface dlt_lap_if import dlt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LAP_W-1:0]   lap_number;
  logic [MIN_W-1:0]   lap_minutes;
  logic [SEC_W-1:0]   lap_seconds;
  logic [MICRO_W-1:0] lap_micros;

  modport source (output valid, output lap_number, output lap_minutes,
                  output lap_seconds, output lap_micros, input ready);
  modport sink (input valid, input lap_number, input lap_minutes,
                input lap_seconds, input lap_micros, output ready);
endinterface

>>> rtl/dlt_cfg_if.sv
// Configuration write channel of the debounced lap timer.
// Depends on dlt_pkg for the index and data widths.
interface dlt_cfg_if import dlt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/dlt_cdiv.sv
// Pipelined long division by a constant, a few quotient bits per stage.
// Carries side data alongside; each stage has its own valid and ready.
module dlt_cdiv #(
  parameter int DIVIDEND_W = 40,
  parameter int DIVISOR    = 234375,
  parameter int REM_W      = 18,
  parameter int QUOT_W     = 16,
  parameter int STEP_N     = 4,
  parameter int SIDE_W     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [SIDE_W-1:0]     req_side,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [QUOT_W-1:0]     quotient,
  output logic [REM_W-1:0]      remainder,
  output logic [SIDE_W-1:0]     rsp_side
);

  localparam int STAGE_N = (DIVIDEND_W + STEP_N - 1) / STEP_N;
  localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

  typedef struct packed {
    logic [DIVIDEND_W-1:0] bits;
    logic [REM_W-1:0]      rem;
    logic [QUOT_W-1:0]     quot;
    logic [SIDE_W-1:0]     side;
  } lane_t;

  lane_t pipe [STAGE_N];
  lane_t src [STAGE_N];
  lane_t pipe_next [STAGE_N];
  logic  vld [STAGE_N];
  logic  vin [STAGE_N];
  logic  rdy [STAGE_N+1];

  assign rdy[STAGE_N] = rsp_ready;
  assign req_ready    = rdy[0];

  for (genvar s = 0; s < STAGE_N; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src[s] = '{bits: dividend, rem: '0, quot: '0, side: req_side};
      assign vin[s] = req_valid;
    end else begin : g_rest
      assign src[s] = pipe[s-1];
      assign vin[s] = vld[s-1];
    end

    assign rdy[s] = !vld[s] || rdy[s+1];

    always_comb begin
      lane_t          w;
      logic [REM_W:0] t;
      logic           geq;
      w = src[s];
      for (int j = 0; j < STEP_N; j++) begin
        if (s * STEP_N + j < DIVIDEND_W) begin
          t      = {w.rem, w.bits[DIVIDEND_W-1]};
          w.bits = w.bits << 1;
          geq    = (t >= DIV_C);
          w.quot = {w.quot[QUOT_W-2:0], geq};
          w.rem  = geq ? REM_W'(t - DIV_C) : REM_W'(t);
        end
      end
      pipe_next[s] = w;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vin[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vin[s]) begin
        pipe[s] <= pipe_next[s];
      end
    end
  end

  assign rsp_valid = vld[STAGE_N-1];
  assign quotient  = pipe[STAGE_N-1].quot;
  assign remainder = pipe[STAGE_N-1].rem;
  assign rsp_side  = pipe[STAGE_N-1].side;

endmodule

>>> rtl/debounced_lap_timer.sv
// Channel  Role    Payload
// cfg      sink    index, data (register write)
// item     sink    func, now_us
// lap      source  lap_number, lap_minutes, lap_seconds, lap_micros
//
// One item is taken every cycle while item.ready is high; its state update completes in the cycle it is accepted.
// A lap result passes through one front register, then
// ceil((TIME_BITS-8)/4) minute divider stages and five second divider stages.
// Reset is synchronous; the configuration registers return to their defaults.
// A stalled lap channel fills the divider stages before item.ready drops.
// Top level of the debounced lap timer; uses dlt_pkg, the three channel
// interfaces, dlt_cdiv and the assertion macros header.
`include "debounced_lap_timer_macros.svh"

module debounced_lap_timer import dlt_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input logic         clk,
  input logic         rst,
  dlt_cfg_if.sink     cfg,
  dlt_item_if.sink    item,
  dlt_lap_if.source   lap
);

  localparam int MDIV_W  = TIME_BITS - MIN_SHIFT;
  localparam int MSIDE_W = LAP_W + MIN_SHIFT;
  localparam int SDIV_W  = MIN_REM_W + MIN_SHIFT - SEC_SHIFT;
  localparam int SSIDE_W = LAP_W + MIN_W + SEC_SHIFT;

  logic [MIN_LAP_W-1:0] min_lap_us;
  logic [QUIET_W-1:0]   quiet_us;

  logic [TIME_BITS-1:0] lap_reference_time;
  logic [TIME_BITS-1:0] lap_reference_time_next;
  logic [TIME_BITS-1:0] last_edge_time;
  logic [TIME_BITS-1:0] last_edge_time_next;
  logic                 trigger_spent;
  logic                 trigger_spent_next;
  logic [LAP_W-1:0]     lap_count;
  logic [LAP_W-1:0]     lap_count_next;

  logic                 item_acc;
  logic [TIME_BITS-1:0] since_edge;
  logic [TIME_BITS-1:0] elapsed;
  logic                 fire;
  logic                 lap_ok;
  logic                 fired;
  logic                 emit;

  logic                 f_vld;
  logic [TIME_BITS-1:0] f_elapsed;
  logic [LAP_W-1:0]     f_lap_number;

  logic                 mdiv_ready;
  logic                 m_valid;
  logic                 m_ready;
  logic [MIN_W-1:0]     m_quot;
  logic [MIN_REM_W-1:0] m_rem;
  logic [MSIDE_W-1:0]   m_side;

  logic [SEC_W-1:0]     s_quot;
  logic [SEC_REM_W-1:0] s_rem;
  logic [SSIDE_W-1:0]   s_side;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_lap_us <= MIN_LAP_RESET;
      quiet_us   <= QUIET_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MIN_LAP: min_lap_us <= cfg.data[MIN_LAP_W-1:0];
        CFG_QUIET:   quiet_us   <= cfg.data[QUIET_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.ready = !f_vld || mdiv_ready;
  assign item_acc   = item.valid && item.ready;
  assign since_edge = item.now_us - last_edge_time;
  assign elapsed    = item.now_us - lap_reference_time;
  assign fire       = !trigger_spent && (since_edge > TIME_BITS'(quiet_us));
  assign lap_ok     = elapsed >= TIME_BITS'(min_lap_us);

  always_comb begin
    lap_reference_time_next = lap_reference_time;
    last_edge_time_next     = last_edge_time;
    trigger_spent_next      = trigger_spent;
    lap_count_next          = lap_count;
    fired                   = 1'b0;
    emit                    = 1'b0;
    if (item_acc) begin
      case (item.func)
        FUNC_START: begin
          lap_count_next          = '0;
          lap_reference_time_next = item.now_us;
        end
        FUNC_EDGE: begin
          last_edge_time_next = item.now_us;
          trigger_spent_next  = 1'b0;
        end
        FUNC_POLL: begin
          if (fire) begin
            fired                   = 1'b1;
            trigger_spent_next      = 1'b1;
            lap_reference_time_next = item.now_us;
            if (lap_ok) begin
              lap_count_next = lap_count + 1'b1;
              emit           = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lap_reference_time <= '0;
      last_edge_time     <= '0;
      trigger_spent      <= 1'b0;
      lap_count          <= '0;
      f_vld              <= 1'b0;
    end else begin
      lap_reference_time <= lap_reference_time_next;
      last_edge_time     <= last_edge_time_next;
      trigger_spent      <= trigger_spent_next;
      lap_count          <= lap_count_next;
      if (item.ready) begin
        f_vld <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      f_elapsed    <= elapsed;
      f_lap_number <= lap_count_next;
    end
  end

  dlt_cdiv #(
    .DIVIDEND_W (MDIV_W),
    .DIVISOR    (MIN_DIVISOR),
    .REM_W      (MIN_REM_W),
    .QUOT_W     (MIN_W),
    .STEP_N     (DIV_STEPS),
    .SIDE_W     (MSIDE_W)
  ) u_min_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (f_vld),
    .req_ready (mdiv_ready),
    .dividend  (f_elapsed[TIME_BITS-1:MIN_SHIFT]),
    .req_side  ({f_lap_number, f_elapsed[MIN_SHIFT-1:0]}),
    .rsp_valid (m_valid),
    .rsp_ready (m_ready),
    .quotient  (m_quot),
    .remainder (m_rem),
    .rsp_side  (m_side)
  );

  dlt_cdiv #(
    .DIVIDEND_W (SDIV_W),
    .DIVISOR    (SEC_DIVISOR),
    .REM_W      (SEC_REM_W),
    .QUOT_W     (SEC_W),
    .STEP_N     (DIV_STEPS),
    .SIDE_W     (SSIDE_W)
  ) u_sec_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (m_valid),
    .req_ready (m_ready),
    .dividend  ({m_rem, m_side[MIN_SHIFT-1:SEC_SHIFT]}),
    .req_side  ({m_side[MSIDE_W-1:MIN_SHIFT], m_quot, m_side[SEC_SHIFT-1:0]}),
    .rsp_valid (lap.valid),
    .rsp_ready (lap.ready),
    .quotient  (s_quot),
    .remainder (s_rem),
    .rsp_side  (s_side)
  );

  assign lap.lap_number  = s_side[SSIDE_W-1:MIN_W+SEC_SHIFT];
  assign lap.lap_minutes = s_side[MIN_W+SEC_SHIFT-1:SEC_SHIFT];
  assign lap.lap_seconds = s_quot;
  assign lap.lap_micros  = {s_rem, s_side[SEC_SHIFT-1:0]};

  `DLT_ASSERT_HOLDS(a_emit_needs_fire, emit, item_acc && item.func == FUNC_POLL && fired, "lap emitted without a firing poll")
  `DLT_ASSERT_NEXT(a_spent_after_fire, fired, trigger_spent, "trigger still armed after firing")
  `DLT_ASSERT_NEXT(a_count_steps, emit, lap_count == LAP_W'($past(lap_count) + 1'b1), "lap count did not advance by one")
  `DLT_ASSERT_NEXT(a_front_holds, f_vld && !mdiv_ready, f_vld && $stable(f_elapsed), "front register lost a stalled lap")

endmodule

>>> tb/sv/tb_debounced_lap_timer.sv
`timescale 1ns / 100ps
// Self-checking testbench for debounced_lap_timer: a directed table, then random lap sequences.
// Uses dlt_pkg and the dlt_cfg_if, dlt_item_if and dlt_lap_if channel interfaces.
module tb_debounced_lap_timer;
  import dlt_pkg::*;

  localparam int TIME_W = DEF_TIME_BITS;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [LAP_W-1:0] number;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [MICRO_W-1:0] micros;
  } lap_t;

  typedef enum logic [1:0] {PIN_PREDICT, PIN_NONE, PIN_LAP} pin_t;

  typedef struct packed {
    logic [FUNC_W-1:0] kind;
    logic [TIME_W-1:0] stamp;
    pin_t pin;
    lap_t lap;
  } row_t;

  localparam lap_t NO_LAP = '0;

  localparam row_t DIRECTED [22] = '{
    '{FUNC_SPARE, TIME_MAX, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd2000001, PIN_LAP, '{16'd1, 16'd0, 6'd2, 20'd1}},
    '{FUNC_POLL, 48'd9000000, PIN_NONE, NO_LAP},
    '{FUNC_EDGE, 48'd9000000, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd9015000, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd9015001, PIN_LAP, '{16'd2, 16'd0, 6'd7, 20'd15000}},
    '{FUNC_EDGE, 48'd10000000, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd11015000, PIN_NONE, NO_LAP},
    '{FUNC_START, 48'd20000000, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd90000000, PIN_NONE, NO_LAP},
    '{FUNC_EDGE, 48'd90000000, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd140000000, PIN_LAP, '{16'd1, 16'd2, 6'd0, 20'd0}},
    '{FUNC_START, TIME_MAX, PIN_NONE, NO_LAP},
    '{FUNC_EDGE, TIME_MAX, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd3000000, PIN_LAP, '{16'd1, 16'd0, 6'd3, 20'd1}},
    '{FUNC_EDGE, 48'd2979999, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd2999999, PIN_PREDICT, NO_LAP},
    '{FUNC_EDGE, 48'd0, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'd0, PIN_NONE, NO_LAP},
    '{FUNC_POLL, TIME_MAX, PIN_PREDICT, NO_LAP},
    '{FUNC_START, 48'd0, PIN_NONE, NO_LAP},
    '{FUNC_POLL, 48'h8000_0000_0000, PIN_NONE, NO_LAP}
  };

  logic clk;
  logic rst;

  dlt_cfg_if cfg_ch ();
  dlt_item_if #(.TIME_BITS(TIME_W)) item_ch ();
  dlt_lap_if lap_ch ();

  debounced_lap_timer #(.TIME_BITS(TIME_W)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .item(item_ch),
    .lap(lap_ch)
  );

  logic [TIME_W-1:0] lap_ref_us;
  logic [TIME_W-1:0] edge_us;
  bit trigger_spent;
  logic [LAP_W-1:0] laps_done;
  logic [MIN_LAP_W-1:0] min_lap_set;
  logic [QUIET_W-1:0] quiet_set;

  lap_t laps_due[$];
  pin_t pin_kind;
  lap_t pin_lap;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned item_gap_max;
  int unsigned lap_stall_max;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit advance_timer(input logic [FUNC_W-1:0] kind,
                                       input logic [TIME_W-1:0] stamp, output lap_t lap);
    logic [TIME_W-1:0] quiet_gap;
    logic [TIME_W-1:0] elapsed;
    longint unsigned span;
    advance_timer = 1'b0;
    lap = '0;
    case (kind)
      FUNC_START: begin
        laps_done = '0;
        lap_ref_us = stamp;
      end
      FUNC_EDGE: begin
        edge_us = stamp;
        trigger_spent = 1'b0;
      end
      FUNC_POLL: begin
        quiet_gap = stamp - edge_us;
        if (!trigger_spent && quiet_gap > TIME_W'(quiet_set)) begin
          trigger_spent = 1'b1;
          elapsed = stamp - lap_ref_us;
          lap_ref_us = stamp;
          if (elapsed >= TIME_W'(min_lap_set)) begin
            laps_done = laps_done + 1'b1;
            span = 64'(elapsed);
            lap.number = laps_done;
            lap.minutes = MIN_W'(span / US_PER_MIN);
            lap.seconds = SEC_W'((span % US_PER_MIN) / US_PER_SEC);
            lap.micros = MICRO_W'(span % US_PER_SEC);
            advance_timer = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string label, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : lap_checker
    lap_t lap;
    lap_t want;
    bit fired;
    bit moved;
    if (rst) begin
      lap_ref_us = '0;
      edge_us = '0;
      trigger_spent = 1'b0;
      laps_done = '0;
      min_lap_set = MIN_LAP_RESET;
      quiet_set = QUIET_RESET;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        if (cfg_ch.index == CFG_MIN_LAP) begin
          min_lap_set = cfg_ch.data;
        end else if (cfg_ch.index == CFG_QUIET) begin
          quiet_set = cfg_ch.data[QUIET_W-1:0];
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        moved = 1'b1;
        fired = advance_timer(item_ch.func, item_ch.now_us, lap);
        case (pin_kind)
          PIN_LAP: laps_due.push_back(pin_lap);
          PIN_PREDICT: if (fired) laps_due.push_back(lap);
          default: ;
        endcase
      end
      if (lap_ch.valid && lap_ch.ready) begin
        moved = 1'b1;
        if (laps_due.size() == 0) begin
          $display("%0t: unexpected lap result, expected none, actual lap_number %0d",
                   $time, lap_ch.lap_number);
          mismatches++;
        end else begin
          want = laps_due.pop_front();
          check_field("lap_number", want.number, lap_ch.lap_number);
          check_field("lap_minutes", want.minutes, lap_ch.lap_minutes);
          check_field("lap_seconds", want.seconds, lap_ch.lap_seconds);
          check_field("lap_micros", want.micros, lap_ch.lap_micros);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_debounced_lap_timer: FAIL");
    $finish;
  end

  initial begin : lap_receiver
    int unsigned stall;
    lap_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, lap_stall_max);
      if (stall > 0) begin
        lap_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      lap_ch.ready <= 1'b1;
      do @(posedge clk); while (!(lap_ch.valid && lap_ch.ready));
      @(negedge clk);
    end
  end

  function automatic logic [TIME_W-1:0] any_time();
    any_time = TIME_W'({$urandom, $urandom});
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] kind, input logic [TIME_W-1:0] stamp,
                           input pin_t pin = PIN_PREDICT, input lap_t typed = '0);
    int unsigned gap;
    gap = $urandom_range(0, item_gap_max);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.func <= kind;
    item_ch.now_us <= stamp;
    pin_kind = pin;
    pin_lap = typed;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    @(negedge clk);
    if (kind != FUNC_SPARE) items_sent++;
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (laps_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
  endtask

  task automatic program_timer(input logic [MIN_LAP_W-1:0] min_lap,
                               input logic [QUIET_W-1:0] quiet);
    write_reg(CFG_MIN_LAP, min_lap);
    write_reg(CFG_QUIET, {8'($urandom), quiet});
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_lap();
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] fire_at;
    logic [TIME_W-1:0] last_edge;
    logic [TIME_W-1:0] hop;
    int unsigned bounces;
    if ($urandom_range(0, 7) == 0) begin
      send_item(FUNC_START, ($urandom_range(0, 3) == 0) ? any_time()
                            : lap_ref_us + TIME_W'($urandom_range(0, 1000000)));
    end
    case ($urandom_range(0, 9))
      0: span = (min_lap_set == '0) ? '0 : TIME_W'(min_lap_set) - 1'b1;
      1: span = TIME_W'(min_lap_set);
      2: span = any_time();
      default: span = TIME_W'(min_lap_set) + TIME_W'($urandom_range(0, 3 * US_PER_MIN));
    endcase
    fire_at = lap_ref_us + span;
    last_edge = fire_at - TIME_W'(quiet_set) - 1'b1 - TIME_W'($urandom_range(0, 2));
    bounces = $urandom_range(0, 3);
    hop = TIME_W'($urandom_range(1, 4000));
    for (int i = bounces; i > 0; i--) begin
      send_item(FUNC_EDGE, last_edge - TIME_W'(i) * hop);
    end
    send_item(FUNC_EDGE, last_edge);
    repeat ($urandom_range(0, 2)) begin
      send_item(FUNC_POLL, last_edge + TIME_W'($urandom_range(0, quiet_set)));
    end
    if ($urandom_range(0, 3) == 0) send_item(FUNC_POLL, last_edge + TIME_W'(quiet_set));
    send_item(FUNC_POLL, fire_at);
    if ($urandom_range(0, 3) == 0) begin
      send_item(FUNC_POLL, fire_at + TIME_W'($urandom_range(0, 1000000)));
    end
  endtask

  task automatic send_noise();
    logic [FUNC_W-1:0] kind;
    repeat ($urandom_range(1, 4)) begin
      kind = FUNC_W'($urandom_range(FUNC_START, FUNC_SPARE));
      send_item(kind, ($urandom_range(0, 1) == 0) ? any_time()
                      : edge_us + TIME_W'($urandom_range(0, 2 * quiet_set + 2)));
    end
  endtask

  task automatic random_phase(input logic [MIN_LAP_W-1:0] min_lap,
                              input logic [QUIET_W-1:0] quiet, input int unsigned count);
    int unsigned items_base;
    settle();
    program_timer(min_lap, quiet);
    item_gap_max = 12;
    lap_stall_max = 12;
    items_base = items_sent;
    while (items_sent - items_base < count) begin
      if ($urandom_range(0, 7) == 0) item_gap_max = $urandom_range(0, 1) * 12;
      if ($urandom_range(0, 7) == 0) lap_stall_max = $urandom_range(0, 1) * 12;
      if ($urandom_range(0, 9) < 8) begin
        run_lap();
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic lap_burst();
    logic [TIME_W-1:0] stamp;
    settle();
    program_timer('0, '0);
    item_gap_max = 0;
    lap_stall_max = 0;
    stamp = any_time();
    repeat (50) begin
      stamp = stamp + TIME_W'($urandom_range(1, 5000));
      send_item(FUNC_EDGE, stamp);
      send_item(FUNC_POLL, stamp + TIME_W'($urandom_range(1, 4)));
    end
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.func = FUNC_START;
    item_ch.now_us = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MIN_LAP;
    cfg_ch.data = '0;
    pin_kind = PIN_PREDICT;
    pin_lap = '0;
    mismatches = 0;
    idle_cycles = 0;
    items_sent = 0;
    item_gap_max = 12;
    lap_stall_max = 12;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].kind, DIRECTED[i].stamp, DIRECTED[i].pin, DIRECTED[i].lap);
    end

    random_phase(MIN_LAP_RESET, QUIET_RESET, 120);
    random_phase('0, '0, 100);
    random_phase('1, '1, 100);
    lap_burst();
    random_phase(MIN_LAP_W'($urandom_range(1, 8000000)),
                 QUIET_W'($urandom_range(1, 200000)), 140);
    random_phase(1, 1, 100);

    settle();
    if (mismatches == 0 && laps_due.size() == 0) begin
      $display("tb_debounced_lap_timer: PASS");
    end else begin
      $display("tb_debounced_lap_timer: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/dlt_pkg.sv
rtl/dlt_item_if.sv
rtl/dlt_lap_if.sv
rtl/dlt_cfg_if.sv
rtl/dlt_cdiv.sv
rtl/debounced_lap_timer.sv
tb/sv/tb_debounced_lap_timer.sv
